// ----- design/shsa_pkg.sv -----
// Shared types, codes and constants of the salted handle slot allocator.
package shsa_pkg;

  localparam int MaxSlots   = 16;
  localparam int SlotIdxW   = 4;
  localparam int SlotCountDefault = 16;
  localparam logic [15:0] BlobBytes = 16'd48;

  localparam logic [31:0] SaltSeed     = 32'hA5A5_A5A5;
  localparam logic [31:0] RerollXor    = 32'hDEAD_BEEF;
  localparam logic [31:0] HandleTopBit = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_SEAL    = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    MAC_AUTHENTIC = 2'd0,
    MAC_MISMATCH  = 2'd1,
    MAC_NO_KEY    = 2'd2
  } mac_code_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_MAC_BAD    = 3'd2,
    ST_NO_KEY     = 3'd3,
    ST_FULL       = 3'd4,
    ST_STORE_FAIL = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_code_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] blob_length;
    logic [1:0]  mac_verdict;
    logic        store_ok;
    logic [31:0] handle_in;
  } shsa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [3:0]  slot_out;
  } shsa_rsp_t;

  // Controller to datapath strobes.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } shsa_ctl_t;

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

  function automatic logic [31:0] rotl7(input logic [31:0] v);
    return {v[24:0], v[31:25]};
  endfunction

endpackage

// ----- design/salted_handle_slot_allocator.sv -----
// Top level of the salted handle slot allocator.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------
//   request | cmd_valid | cmd_stall | cmd: command, blob_length, mac_verdict,
//           |           |           |      store_ok, handle_in
//   result  | rsp_valid | rsp_stall | rsp: status, handle_out, slot_out
//
// One request at a time: transfer in, slot search and handle match in the lookup
// state, update of bitmap and salt and load of the result register in the commit
// state, then the result is offered. A stalled result holds off the next transfer
// in. Reset empties the bitmap and loads the salt seed; no request is taken while
// a result waits.
module salted_handle_slot_allocator
  import shsa_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  shsa_req_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output shsa_rsp_t rsp
);

  shsa_ctl_t ctl;

  shsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  shsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (cmd),
    .rsp (rsp)
  );

endmodule

// ----- design/shsa_ctrl.sv -----
// Sequencing state machine of the slot allocator: handshakes and step strobes.
module shsa_ctrl
  import shsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output shsa_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_LOOKUP  = 4'b0010,
    S_COMMIT  = 4'b0100,
    S_RESPOND = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (cmd_valid) state_next = S_LOOKUP;
      S_LOOKUP:  state_next = S_COMMIT;
      S_COMMIT:  state_next = S_RESPOND;
      S_RESPOND: if (!rsp_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign cmd_stall   = (state != S_IDLE);
  assign rsp_valid   = (state == S_RESPOND);
  assign ctl.capture = (state == S_IDLE) && cmd_valid;
  assign ctl.lookup  = (state == S_LOOKUP);
  assign ctl.commit  = (state == S_COMMIT);

endmodule

// ----- design/shsa_datapath.sv -----
// Datapath of the slot allocator: bitmap, salt, slot search and result register.
module shsa_datapath
  import shsa_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  shsa_ctl_t ctl,
  input  shsa_req_t req,
  output shsa_rsp_t rsp
);

  shsa_req_t             item;
  logic [SLOT_COUNT-1:0] used, used_next;
  logic [31:0]           salt, salt_next;
  logic                  free_found, free_found_q;
  logic [SlotIdxW-1:0]   free_idx, free_idx_q;
  logic                  hit, hit_q;
  logic [SlotIdxW-1:0]   hit_slot, hit_slot_q;
  logic [31:0]           salt_key;
  logic [MaxSlots-1:0]   used_ext;
  logic [31:0]           reroll;
  shsa_rsp_t             rsp_next;

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  // A handle names exactly one slot: undo the salt on the low bits, check the rest.
  assign salt_key = rotl13(salt);
  assign used_ext = MaxSlots'(used);
  assign hit_slot = item.handle_in[SlotIdxW-1:0] ^ salt_key[SlotIdxW-1:0];
  assign hit      = item.handle_in[31]
                 && (item.handle_in[30:SlotIdxW] == salt_key[30:SlotIdxW])
                 && used_ext[hit_slot];

  assign reroll = rotl7(salt) ^ RerollXor;

  always_comb begin
    used_next = used;
    salt_next = salt;
    rsp_next  = '0;
    rsp_next.status = ST_OK;
    unique case (item.command)
      CMD_CLEAR: begin
        used_next = '0;
        salt_next = (reroll == '0) ? SaltSeed : reroll;
      end
      CMD_SEAL: begin
        priority if (item.blob_length != BlobBytes) begin
          rsp_next.status = ST_BAD_SIZE;
        end else if (item.mac_verdict == MAC_NO_KEY) begin
          rsp_next.status = ST_NO_KEY;
        end else if (item.mac_verdict != MAC_AUTHENTIC) begin
          rsp_next.status = ST_MAC_BAD;
        end else if (!free_found_q) begin
          rsp_next.status = ST_FULL;
        end else if (!item.store_ok) begin
          rsp_next.status   = ST_STORE_FAIL;
          rsp_next.slot_out = free_idx_q;
        end else begin
          used_next[free_idx_q] = 1'b1;
          rsp_next.handle_out = (32'(free_idx_q) ^ salt_key) | HandleTopBit;
          rsp_next.slot_out   = free_idx_q;
        end
      end
      CMD_RESOLVE: begin
        if (hit_q) begin
          rsp_next.slot_out = hit_slot_q;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      salt <= SaltSeed;
    end else if (ctl.commit) begin
      used <= used_next;
      salt <= salt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= req;
    end
    if (ctl.lookup) begin
      free_found_q <= free_found;
      free_idx_q   <= free_idx;
      hit_q        <= hit;
      hit_slot_q   <= hit_slot;
    end
    if (ctl.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- tb/tb_salted_handle_slot_allocator.sv -----
// Self-checking testbench for the salted handle slot allocator: directed and random traffic.
`timescale 1ns / 100ps

module tb_salted_handle_slot_allocator;
  import shsa_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [1:0] MacUnused = 2'd3;
  localparam int RandomItems    = 1150;
  localparam int QuietItems     = 150;
  localparam int LongHoldAt     = 350;
  localparam int LongHoldCycles = 60;
  localparam int TailCycles     = 16;
  localparam int SlotLimit      = (SlotCountDefault > MaxSlots) ? MaxSlots : SlotCountDefault;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  shsa_req_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  shsa_rsp_t rsp;

  salted_handle_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Predicted block state.
  logic [15:0] slot_map = '0;
  logic [31:0] salt_now = SaltSeed;
  // Salt as the stimulus generator sees it, to build resolvable handles.
  logic [31:0] gen_salt = SaltSeed;

  shsa_req_t   req_backlog[$];
  shsa_rsp_t   awaited_rsps[$];
  int unsigned accepted_reqs = 0;
  int unsigned quiet_after = 32'hFFFF_FFFF;
  int          errors = 0;
  logic        cmd_taken = 1'b0;
  int          send_gap = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] reroll(input logic [31:0] s);
    logic [31:0] t;
    t = rot_left(s, 7) ^ RerollXor;
    return (t == 32'd0) ? SaltSeed : t;
  endfunction

  function automatic logic [31:0] slot_handle(input logic [31:0] s, input logic [3:0] slot);
    return ({28'd0, slot} ^ rot_left(s, 13)) | HandleTopBit;
  endfunction

  // Update the predicted bitmap and salt, return the response this request earns.
  function automatic shsa_rsp_t next_response(input shsa_req_t req);
    shsa_rsp_t r;
    logic      found;
    logic [3:0] pick;
    int        i;
    r = '0;
    found = 1'b0;
    pick = '0;
    case (req.command)
      CMD_CLEAR: begin
        slot_map = '0;
        salt_now = reroll(salt_now);
      end
      CMD_SEAL: begin
        if (req.blob_length != BlobBytes) begin
          r.status = ST_BAD_SIZE;
        end else if (req.mac_verdict == MAC_NO_KEY) begin
          r.status = ST_NO_KEY;
        end else if (req.mac_verdict != MAC_AUTHENTIC) begin
          r.status = ST_MAC_BAD;
        end else begin
          // scan downward so the lowest free slot wins
          for (i = SlotLimit - 1; i >= 0; i--) begin
            if (!slot_map[i]) begin
              pick = 4'(i);
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = ST_FULL;
          end else if (!req.store_ok) begin
            r.status = ST_STORE_FAIL;
            r.slot_out = pick;
          end else begin
            slot_map[pick] = 1'b1;
            r.handle_out = slot_handle(salt_now, pick);
            r.slot_out = pick;
          end
        end
      end
      CMD_RESOLVE: begin
        r.status = ST_NOT_FOUND;
        for (i = SlotLimit - 1; i >= 0; i--) begin
          if (slot_map[i] && slot_handle(salt_now, 4'(i)) == req.handle_in) begin
            r.status = ST_OK;
            r.slot_out = 4'(i);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [15:0] len,
                           input logic [1:0] mac, input logic ok, input logic [31:0] h);
    shsa_req_t q;
    q.command     = op;
    q.blob_length = len;
    q.mac_verdict = mac;
    q.store_ok    = ok;
    q.handle_in   = h;
    req_backlog.push_back(q);
    if (op == CMD_CLEAR) gen_salt = reroll(gen_salt);
  endtask

  // Request driver: hold a stalled transfer, otherwise idle or present the next item.
  always @(negedge clk) begin
    shsa_req_t nxt_cmd;
    logic      nxt_valid;
    nxt_cmd = cmd;
    nxt_valid = cmd_valid;
    if (!rst && !(cmd_valid && !cmd_taken)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_backlog.size() > 0) begin
        if (accepted_reqs < quiet_after && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 9);
        end else begin
          nxt_cmd = req_backlog.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    cmd <= nxt_cmd;
    cmd_valid <= nxt_valid;
  end

  // Response stall: random bursts plus one long hold-off to back up the block.
  always @(negedge clk) begin
    logic nxt_stall;
    if (rst) begin
      nxt_stall = 1'b0;
    end else if (!long_hold_done && accepted_reqs >= LongHoldAt) begin
      hold_left = LongHoldCycles - 1;
      long_hold_done = 1'b1;
      nxt_stall = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (accepted_reqs < quiet_after && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 9);
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = 1'b0;
    end
    rsp_stall <= nxt_stall;
  end

  // Monitor: predict on each request transfer, check each response transfer.
  always @(posedge clk) begin
    shsa_rsp_t want;
    if (rst) begin
      cmd_taken = 1'b0;
    end else begin
      cmd_taken = cmd_valid && !cmd_stall;
      if (cmd_taken) begin
        awaited_rsps.push_back(next_response(cmd));
        accepted_reqs++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected response transfer: status %0d handle %h slot %0d",
                 rsp.status, rsp.handle_out, rsp.slot_out);
          errors++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.handle_out !== want.handle_out) begin
            $error("handle_out: expected %h, actual %h", want.handle_out, rsp.handle_out);
            errors++;
          end
          if (rsp.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, rsp.slot_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int          sent;
    int          run_len;
    int          k;
    int          pick;
    logic        fill_run;
    logic [31:0] h;
    logic [31:0] old_handle;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-map resolve, length and MAC checks, store failure, hits and misses.
    queue_req(CMD_RESOLVE, 16'hFFFF, MacUnused, 1'b1, slot_handle(gen_salt, 4'd0));
    queue_req(CMD_SEAL, BlobBytes, MAC_AUTHENTIC, 1'b1, 32'hFFFF_FFFF);
    queue_req(CMD_SEAL, BlobBytes - 16'd1, MAC_AUTHENTIC, 1'b1, 32'd0);
    queue_req(CMD_SEAL, BlobBytes + 16'd1, MAC_AUTHENTIC, 1'b1, 32'd0);
    queue_req(CMD_SEAL, 16'h0000, MAC_NO_KEY, 1'b1, 32'd0);
    queue_req(CMD_SEAL, 16'hFFFF, MAC_AUTHENTIC, 1'b1, 32'd0);
    queue_req(CMD_SEAL, BlobBytes, MAC_MISMATCH, 1'b1, 32'd0);
    queue_req(CMD_SEAL, BlobBytes, MAC_NO_KEY, 1'b1, 32'd0);
    queue_req(CMD_SEAL, BlobBytes, MacUnused, 1'b1, 32'd0);
    queue_req(CMD_SEAL, BlobBytes, MAC_AUTHENTIC, 1'b0, 32'd0);
    queue_req(CMD_SEAL, BlobBytes, MAC_AUTHENTIC, 1'b1, 32'd0);
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, slot_handle(gen_salt, 4'd1));
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, slot_handle(gen_salt, 4'd0));
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0,
              slot_handle(gen_salt, 4'd0) & ~HandleTopBit);
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, slot_handle(gen_salt, 4'd2));
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, 32'hFFFF_FFFF);
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, 32'd0);
    queue_req(CmdUnused, 16'hFFFF, MacUnused, 1'b1, 32'hFFFF_FFFF);
    old_handle = slot_handle(gen_salt, 4'd0);
    queue_req(CMD_CLEAR, 16'hFFFF, MacUnused, 1'b1, 32'hFFFF_FFFF);
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, old_handle);
    queue_req(CMD_SEAL, BlobBytes, MAC_AUTHENTIC, 1'b1, 32'd0);
    queue_req(CMD_RESOLVE, 16'd0, MAC_AUTHENTIC, 1'b0, slot_handle(gen_salt, 4'd0));

    // Let the sender run dry until every response is back.
    while (req_backlog.size() != 0 || cmd_valid || awaited_rsps.size() != 0) @(posedge clk);

    // Random runs: mostly good seals and resolves of issued handles, some noise,
    // each run closed by a clear. Fill runs push the map toward full.
    sent = 0;
    while (sent < RandomItems) begin
      fill_run = ($urandom_range(0, 3) == 0);
      run_len = fill_run ? $urandom_range(18, 28) : $urandom_range(4, 40);
      for (k = 0; k < run_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < (fill_run ? 75 : 40)) begin
          queue_req(CMD_SEAL, BlobBytes, MAC_AUTHENTIC, ($urandom_range(0, 9) != 0),
                    $urandom());
        end else if (pick < (fill_run ? 95 : 75)) begin
          h = slot_handle(gen_salt, 4'($urandom_range(0, 15)));
          case ($urandom_range(0, 9))
            0: h = $urandom();
            1: h[31] = 1'b0;
            2: h = h ^ (32'h1 << $urandom_range(0, 30));
            default: ;
          endcase
          queue_req(CMD_RESOLVE, 16'($urandom()), 2'($urandom()), 1'($urandom()), h);
        end else begin
          case ($urandom_range(0, 3))
            0: queue_req(CMD_SEAL, 16'($urandom()), 2'($urandom()), 1'($urandom()),
                         $urandom());
            1: queue_req(CMD_SEAL, BlobBytes, 2'($urandom_range(1, 3)), 1'($urandom()),
                         $urandom());
            2: queue_req(CmdUnused, 16'($urandom()), 2'($urandom()), 1'($urandom()),
                         $urandom());
            default: queue_req(2'($urandom()), 16'($urandom()), 2'($urandom()),
                               1'($urandom()), $urandom());
          endcase
        end
      end
      queue_req(CMD_CLEAR, 16'($urandom()), 2'($urandom()), 1'($urandom()), $urandom());
      sent += run_len + 1;
    end
    quiet_after = accepted_reqs + req_backlog.size() - QuietItems;

    while (req_backlog.size() != 0 || cmd_valid || awaited_rsps.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
